// ----- hw/rtl/lrsf_pkg.sv -----
// ---------------------------------------------------------------------------
// lrsf_pkg: shared definitions for the laser range spike filter
// Register map, register widths and reset values, and the configuration
// bundle that the register block hands to the filter core.
// ---------------------------------------------------------------------------
`default_nettype none

package lrsf_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned RANGE_CFG_W = 16;
  localparam int unsigned RATIO_W     = 4;
  localparam int unsigned PERMILLE_W  = 12;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_MIN_RANGE  = 3'd0;
  localparam logic [2:0] REG_MAX_RANGE  = 3'd1;
  localparam logic [2:0] REG_MIN_SPREAD = 3'd2;
  localparam logic [2:0] REG_SPIKE_RAT  = 3'd3;
  localparam logic [2:0] REG_REL_JUMP   = 3'd4;

  localparam logic [RANGE_CFG_W-1:0] RST_MIN_RANGE  = 16'd10;
  localparam logic [RANGE_CFG_W-1:0] RST_MAX_RANGE  = 16'd1000;
  localparam logic [RANGE_CFG_W-1:0] RST_MIN_SPREAD = 16'd10;
  localparam logic [RATIO_W-1:0]     RST_SPIKE_RAT  = 4'd2;
  localparam logic [PERMILLE_W-1:0]  RST_REL_JUMP   = 12'd400;

  // Scale of the relative jump test: three samples times one thousand.
  localparam logic [PERMILLE_W-1:0] JUMP_SCALE = 12'd3000;

  typedef struct packed {
    logic [RANGE_CFG_W-1:0] min_range_mm;
    logic [RANGE_CFG_W-1:0] max_range_mm;
    logic [RANGE_CFG_W-1:0] min_spread_mm;
    logic [RATIO_W-1:0]     spike_ratio;
    logic [PERMILLE_W-1:0]  relative_jump_permille;
  } lrsf_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrsf_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// lrsf_cfg_regs: configuration register block
// APB-style register file holding the filter thresholds. Always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module lrsf_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [lrsf_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [lrsf_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic      [lrsf_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready,
  output lrsf_pkg::lrsf_cfg_t                    cfg
);

  lrsf_pkg::lrsf_cfg_t cfg_r;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range_mm           <= lrsf_pkg::RST_MIN_RANGE;
      cfg_r.max_range_mm           <= lrsf_pkg::RST_MAX_RANGE;
      cfg_r.min_spread_mm          <= lrsf_pkg::RST_MIN_SPREAD;
      cfg_r.spike_ratio            <= lrsf_pkg::RST_SPIKE_RAT;
      cfg_r.relative_jump_permille <= lrsf_pkg::RST_REL_JUMP;
    end else if (wr_en) begin
      unique case (reg_idx)
        lrsf_pkg::REG_MIN_RANGE: begin
          cfg_r.min_range_mm <= cfg_pwdata[lrsf_pkg::RANGE_CFG_W-1:0];
        end
        lrsf_pkg::REG_MAX_RANGE: begin
          cfg_r.max_range_mm <= cfg_pwdata[lrsf_pkg::RANGE_CFG_W-1:0];
        end
        lrsf_pkg::REG_MIN_SPREAD: begin
          cfg_r.min_spread_mm <= cfg_pwdata[lrsf_pkg::RANGE_CFG_W-1:0];
        end
        lrsf_pkg::REG_SPIKE_RAT: begin
          cfg_r.spike_ratio <= cfg_pwdata[lrsf_pkg::RATIO_W-1:0];
        end
        lrsf_pkg::REG_REL_JUMP: begin
          cfg_r.relative_jump_permille <= cfg_pwdata[lrsf_pkg::PERMILLE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lrsf_pkg::REG_MIN_RANGE:  cfg_prdata = lrsf_pkg::APB_DATA_W'(cfg_r.min_range_mm);
      lrsf_pkg::REG_MAX_RANGE:  cfg_prdata = lrsf_pkg::APB_DATA_W'(cfg_r.max_range_mm);
      lrsf_pkg::REG_MIN_SPREAD: cfg_prdata = lrsf_pkg::APB_DATA_W'(cfg_r.min_spread_mm);
      lrsf_pkg::REG_SPIKE_RAT:  cfg_prdata = lrsf_pkg::APB_DATA_W'(cfg_r.spike_ratio);
      lrsf_pkg::REG_REL_JUMP:
        cfg_prdata = lrsf_pkg::APB_DATA_W'(cfg_r.relative_jump_permille);
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lrsf_core.sv -----
// ---------------------------------------------------------------------------
// lrsf_core: input register and spike decision
// Holds the accepted sample, the pending sample and its filtered left
// neighbour, and pushes zero, one or two results into the output queue.
// ---------------------------------------------------------------------------
`default_nettype none

module lrsf_core #(
  parameter int unsigned RANGE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lrsf_pkg::lrsf_cfg_t   cfg,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [RANGE_BITS-1:0] in_range_mm,
  input  wire logic                  in_last,
  input  wire logic                  q_room,
  output logic [1:0]                 push_cnt,
  output logic [RANGE_BITS:0]        push_d0,
  output logic [RANGE_BITS:0]        push_d1
);

  localparam int unsigned CW = (RANGE_BITS > lrsf_pkg::RANGE_CFG_W) ?
                               RANGE_BITS : lrsf_pkg::RANGE_CFG_W;
  localparam int unsigned LW = CW + lrsf_pkg::RATIO_W;
  localparam int unsigned PW = RANGE_BITS + 2 + lrsf_pkg::PERMILLE_W;

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_FIRST,
    HELD_INNER
  } held_t;

  logic                  stage_valid_r, stage_valid_nxt;
  logic [RANGE_BITS-1:0] stage_range_r;
  logic                  stage_last_r;
  held_t                 held_r, held_nxt;
  logic [RANGE_BITS-1:0] prev_r, prev_nxt;
  logic [RANGE_BITS-1:0] pend_r, pend_nxt;

  logic                  load, advance;
  logic [RANGE_BITS-1:0] p, c, n;
  logic [RANGE_BITS-1:0] d1, d2, spread;
  logic [RANGE_BITS:0]   dsum, pn_sum;
  logic [CW-1:0]         spread_fl;
  logic [LW-1:0]         lim1;
  logic [PW-1:0]         lhs2, rhs2;
  logic                  in_window, test1, test2;
  logic [RANGE_BITS-1:0] despiked, emitted;

  assign advance  = stage_valid_r && q_room;
  assign in_stall = stage_valid_r && !q_room;
  assign load     = in_valid && !in_stall;

  // Spike decision on the pending sample with its neighbours.
  assign p = prev_r;
  assign c = pend_r;
  assign n = stage_range_r;

  assign d1     = (c > p) ? (c - p) : (p - c);
  assign d2     = (c > n) ? (c - n) : (n - c);
  assign spread = (p > n) ? (p - n) : (n - p);
  assign dsum   = (RANGE_BITS+1)'(d1) + (RANGE_BITS+1)'(d2);
  assign pn_sum = (RANGE_BITS+1)'(p) + (RANGE_BITS+1)'(n);

  assign in_window = (CW'(c) > CW'(cfg.min_range_mm)) && (CW'(c) < CW'(cfg.max_range_mm));
  assign spread_fl = (CW'(spread) < CW'(cfg.min_spread_mm)) ?
                     CW'(cfg.min_spread_mm) : CW'(spread);
  assign lim1  = LW'(cfg.spike_ratio) * LW'(spread_fl);
  assign test1 = LW'(dsum) > lim1;
  assign lhs2  = PW'(dsum) * PW'(lrsf_pkg::JUMP_SCALE);
  assign rhs2  = PW'(cfg.relative_jump_permille) *
                 PW'((RANGE_BITS+2)'(p) + (RANGE_BITS+2)'(c) + (RANGE_BITS+2)'(n));
  assign test2 = lhs2 > rhs2;

  assign despiked = (in_window && test1 && test2) ? pn_sum[RANGE_BITS:1] : c;
  assign emitted  = (held_r == HELD_FIRST) ? pend_r : despiked;

  always_comb begin
    push_cnt        = 2'd0;
    push_d0         = {emitted, 1'b0};
    push_d1         = {stage_range_r, 1'b1};
    held_nxt        = held_r;
    prev_nxt        = prev_r;
    pend_nxt        = pend_r;
    stage_valid_nxt = load ? 1'b1 : (advance ? 1'b0 : stage_valid_r);
    if (advance) begin
      unique case (held_r) inside
        HELD_FIRST, HELD_INNER: begin
          push_cnt = stage_last_r ? 2'd2 : 2'd1;
          prev_nxt = emitted;
          pend_nxt = stage_range_r;
          held_nxt = stage_last_r ? HELD_NONE : HELD_INNER;
        end
        default: begin
          if (stage_last_r) begin
            push_cnt = 2'd1;
            push_d0  = {stage_range_r, 1'b1};
            held_nxt = HELD_NONE;
          end else begin
            pend_nxt = stage_range_r;
            held_nxt = HELD_FIRST;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      held_r        <= HELD_NONE;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      held_r        <= held_nxt;
    end
    if (load) begin
      stage_range_r <= in_range_mm;
      stage_last_r  <= in_last;
    end
    prev_r <= prev_nxt;
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lrsf_out_fifo.sv -----
// ---------------------------------------------------------------------------
// lrsf_out_fifo: result queue
// Small register queue taking up to two entries per cycle and releasing one per cycle while the output does not stall.
// DEPTH must be a power of two of at least four.
// ---------------------------------------------------------------------------
`default_nettype none

module lrsf_out_fifo #(
  parameter int unsigned DW    = 17,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    push_cnt,
  input  wire logic [DW-1:0] push_d0,
  input  wire logic [DW-1:0] push_d1,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [DW-1:0]      out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          pop;

  assign out_valid  = count_r != '0;
  assign pop        = out_valid && !out_stall;
  // Room is judged on the registered fill so that the input side does not
  // wait on the output side's stall.
  assign room       = count_r <= NW'(DEPTH - 2);
  assign out_data   = mem[rd_ptr_r];
  assign wr_ptr_p1  = wr_ptr_r + AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + AW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign count_nxt  = count_r + NW'(push_cnt) - NW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push_d1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/laser_range_spike_filter.sv -----
// ---------------------------------------------------------------------------
// laser_range_spike_filter: three point spike filter for laser range scans
// Streams range samples of a scan and replaces isolated spikes by the mean
// of their neighbours.
// ---------------------------------------------------------------------------
// The block accepts one sample transaction per clock cycle and sustains that
// rate indefinitely while the result side keeps up. Each sample is compared
// with its filtered left neighbour and its raw right neighbour, so a sample
// leaves the block one input transaction late: the result for sample k is
// produced when sample k+1 arrives, by way of the input register and the
// queue. The last sample of a scan releases two result transactions, the
// held interior sample and then the last sample itself with last_out set; a
// one-sample scan releases its sample straight away. Results go through a
// four-entry queue, and the input stalls only while that queue holds three
// or more results, which happens only when the result side stalls. The spike
// test, both threshold multiplications and the mean are combinational,
// between the input register and the queue. There is no clearing pass after
// reset. The user must write thresholds through the APB-style port only while
// no scan is in flight; the block does not enforce this. The registers lie
// at byte addresses 0x0 (min_range_mm), 0x4 (max_range_mm), 0x8
// (min_spread_mm), 0xC (spike_ratio) and 0x10 (relative_jump_permille).
// ---------------------------------------------------------------------------
`default_nettype none

module laser_range_spike_filter #(
  parameter int unsigned RANGE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Sample input
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [RANGE_BITS-1:0]            in_range_mm,
  input  wire logic                             in_last,
  // Filtered output
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [RANGE_BITS-1:0]                 out_range_out_mm,
  output logic                                  out_last_out,
  // Configuration
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [lrsf_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [lrsf_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic      [lrsf_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned QDEPTH = 4;

  lrsf_pkg::lrsf_cfg_t cfg;
  logic                q_room;
  logic [1:0]          push_cnt;
  logic [RANGE_BITS:0] push_d0, push_d1, q_data;

  // Threshold registers.
  lrsf_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Input register, held sample state and the spike decision.
  lrsf_core #(
    .RANGE_BITS (RANGE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_range_mm (in_range_mm),
    .in_last     (in_last),
    .q_room      (q_room),
    .push_cnt    (push_cnt),
    .push_d0     (push_d0),
    .push_d1     (push_d1)
  );

  // Result queue; each entry packs the range above the last flag.
  lrsf_out_fifo #(
    .DW    (RANGE_BITS + 1),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .room      (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign out_range_out_mm = q_data[RANGE_BITS:1];
  assign out_last_out     = q_data[0];

endmodule

`default_nettype wire

// ----- hw/rtl/lrsf_checker.sv -----
// ---------------------------------------------------------------------------
// lrsf_checker: port-level checks for the laser range spike filter
// Watches the top-level ports and is bound to every instance of the block.
// ---------------------------------------------------------------------------
`default_nettype none

module lrsf_checker #(
  parameter int unsigned RANGE_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [RANGE_BITS-1:0] out_range_out_mm,
  input wire logic                  out_last_out
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_range_out_mm) &&
                               $stable(out_last_out))
    else $error("result changed while stalled");

  // The input only stalls behind a backed-up result queue.
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Reset empties the queue and the input register.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // With no input right after reset, no result can appear.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && !in_valid ##1 !in_valid |=> !out_valid)
    else $error("result appeared without input");

endmodule

bind laser_range_spike_filter lrsf_checker #(
  .RANGE_BITS (RANGE_BITS)
) u_lrsf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_range_out_mm (out_range_out_mm),
  .out_last_out     (out_last_out)
);

`default_nettype wire

// ----- tb/sv/laser_range_spike_filter_tb.sv -----
// ---------------------------------------------------------------------------
// laser_range_spike_filter_tb: self-checking bench for the range spike filter
// Streams whole scans through the filter under several threshold settings,
// predicts every filtered sample in the bench and compares each result
// transaction against the prediction, field by field, in scan order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module laser_range_spike_filter_tb;

  localparam int unsigned RB          = 16;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RAND_ITEMS  = 140;   // least number of random samples per phase
  localparam int          NUM_PHASES  = 6;
  localparam longint unsigned JUMP_MUL = 3000; // three samples times one thousand

  // What the filter core holds between input transactions.
  typedef enum logic [1:0] {
    HOLD_NONE     = 2'd0,
    HOLD_FIRST    = 2'd1,
    HOLD_INTERIOR = 2'd2
  } hold_t;

  typedef struct packed {
    logic [RB-1:0] range_mm;
    logic          last;
  } sample_t;

  // Clock and reset. Reset is synchronous.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every block input starts at a known value.
  logic                            in_valid    = 1'b0;
  logic [RB-1:0]                   in_range_mm = '0;
  logic                            in_last     = 1'b0;
  logic                            out_stall   = 1'b0;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [lrsf_pkg::APB_ADDR_W-1:0] cfg_paddr   = '0;
  logic [lrsf_pkg::APB_DATA_W-1:0] cfg_pwdata  = '0;

  logic                            in_stall;
  logic                            out_valid;
  logic [RB-1:0]                   out_range_out_mm;
  logic                            out_last_out;
  logic [lrsf_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  laser_range_spike_filter #(.RANGE_BITS(RB)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_range_mm      (in_range_mm),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_range_out_mm (out_range_out_mm),
    .out_last_out     (out_last_out),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // Bench copy of the thresholds, kept in step with every register write.
  logic [lrsf_pkg::RANGE_CFG_W-1:0] thr_min_range  = lrsf_pkg::RST_MIN_RANGE;
  logic [lrsf_pkg::RANGE_CFG_W-1:0] thr_max_range  = lrsf_pkg::RST_MAX_RANGE;
  logic [lrsf_pkg::RANGE_CFG_W-1:0] thr_min_spread = lrsf_pkg::RST_MIN_SPREAD;
  logic [lrsf_pkg::RATIO_W-1:0]     thr_spike_rat  = lrsf_pkg::RST_SPIKE_RAT;
  logic [lrsf_pkg::PERMILLE_W-1:0]  thr_rel_jump   = lrsf_pkg::RST_REL_JUMP;

  // Bench copy of the filter state.
  hold_t         held_state  = HOLD_NONE;
  logic [RB-1:0] left_filt   = '0;
  logic [RB-1:0] held_sample = '0;

  sample_t scan_samples_q[$];   // samples waiting to be driven
  sample_t filtered_due_q[$];   // filtered samples the block still owes us

  int send_idle_pct = 36;
  int recv_idle_pct = 62;
  bit in_accepted   = 1'b0;

  int errors        = 0;
  int cycles        = 0;
  int samples_sent  = 0;
  int results_seen  = 0;
  int spikes_fixed  = 0;
  int scans_queued  = 0;

  // Decide whether sample c, sitting between its filtered left neighbour p
  // and its raw right neighbour n, is a spike, and return what replaces it.
  // All sums are carried at 64 bits so nothing wraps.
  function automatic logic [RB-1:0] despiked(input logic [RB-1:0] p,
                                             input logic [RB-1:0] c,
                                             input logic [RB-1:0] n);
    longint unsigned pw, cw, nw, dist_sum, spread;
    pw = 64'(p);
    cw = 64'(c);
    nw = 64'(n);
    if (!(c > thr_min_range && c < thr_max_range)) return c;
    dist_sum = (cw > pw ? cw - pw : pw - cw) + (cw > nw ? cw - nw : nw - cw);
    spread   = pw > nw ? pw - nw : nw - pw;
    if (spread < longint'(thr_min_spread)) spread = 64'(thr_min_spread);
    // Test one compares against the neighbour spread, test two against the
    // three-sample mean by cross-multiplication, so no division is needed.
    if (dist_sum > longint'(thr_spike_rat) * spread &&
        dist_sum * JUMP_MUL > longint'(thr_rel_jump) * (pw + cw + nw)) begin
      spikes_fixed++;
      return RB'((pw + nw) >> 1);
    end
    return c;
  endfunction

  // Advance the filter state by one accepted sample and queue whatever
  // filtered samples it releases.
  task automatic filter_sample(input logic [RB-1:0] x, input logic lst);
    logic [RB-1:0] emitted;
    if (held_state == HOLD_FIRST || held_state == HOLD_INTERIOR) begin
      emitted = (held_state == HOLD_FIRST) ? held_sample
                                           : despiked(left_filt, held_sample, x);
      filtered_due_q.push_back('{range_mm: emitted, last: 1'b0});
      left_filt   = emitted;
      held_sample = x;
      held_state  = HOLD_INTERIOR;
      if (lst) begin
        // End of scan: the last sample follows the held one unchanged.
        filtered_due_q.push_back('{range_mm: x, last: 1'b1});
        held_state = HOLD_NONE;
      end
    end else if (lst) begin
      // A one-sample scan comes straight out.
      filtered_due_q.push_back('{range_mm: x, last: 1'b1});
      held_state = HOLD_NONE;
    end else begin
      held_sample = x;
      held_state  = HOLD_FIRST;
    end
  endtask

  // Monitor: checks result transactions and feeds accepted input
  // transactions to the prediction. Everything is sampled at the rising edge.
  always @(posedge clk) begin
    sample_t due;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (filtered_due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got range %0d last %0b",
                   $time, out_range_out_mm, out_last_out);
        end else begin
          due = filtered_due_q.pop_front();
          if (out_range_out_mm !== due.range_mm) begin
            errors++;
            $display("%0t: range_out_mm mismatch, expected %0d, got %0d", $time,
                     due.range_mm, out_range_out_mm);
          end
          if (out_last_out !== due.last) begin
            errors++;
            $display("%0t: last_out mismatch, expected %0b, got %0b", $time,
                     due.last, out_last_out);
          end
        end
      end
      if (in_valid && !in_stall) begin
        samples_sent++;
        filter_sample(in_range_mm, in_last);
        in_accepted = 1'b1;
      end
    end
  end

  // Driver: inputs change at the falling edge. A presented sample stays put
  // until the monitor has seen it accepted.
  always @(negedge clk) begin
    sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      in_accepted = 1'b0;
      if (scan_samples_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nxt = scan_samples_q.pop_front();
        in_valid    <= 1'b1;
        in_range_mm <= nxt.range_mm;
        in_last     <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One APB access: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic [2:0] idx, input logic wr,
                            input logic [lrsf_pkg::APB_DATA_W-1:0] wdata,
                            output logic [lrsf_pkg::APB_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write one threshold, mirror it in the bench copy, and read it back.
  task automatic write_threshold(input logic [2:0] idx,
                                 input logic [lrsf_pkg::APB_DATA_W-1:0] val);
    logic [lrsf_pkg::APB_DATA_W-1:0] want, got;
    case (idx)
      lrsf_pkg::REG_MIN_RANGE: begin
        thr_min_range = val[lrsf_pkg::RANGE_CFG_W-1:0];
        want = lrsf_pkg::APB_DATA_W'(thr_min_range);
      end
      lrsf_pkg::REG_MAX_RANGE: begin
        thr_max_range = val[lrsf_pkg::RANGE_CFG_W-1:0];
        want = lrsf_pkg::APB_DATA_W'(thr_max_range);
      end
      lrsf_pkg::REG_MIN_SPREAD: begin
        thr_min_spread = val[lrsf_pkg::RANGE_CFG_W-1:0];
        want = lrsf_pkg::APB_DATA_W'(thr_min_spread);
      end
      lrsf_pkg::REG_SPIKE_RAT: begin
        thr_spike_rat = val[lrsf_pkg::RATIO_W-1:0];
        want = lrsf_pkg::APB_DATA_W'(thr_spike_rat);
      end
      default: begin
        thr_rel_jump = val[lrsf_pkg::PERMILLE_W-1:0];
        want = lrsf_pkg::APB_DATA_W'(thr_rel_jump);
      end
    endcase
    apb_access(idx, 1'b1, val, got);
    apb_access(idx, 1'b0, '0, got);
    if (got !== want) begin
      errors++;
      $display("%0t: readback of register %0d, expected %0d, got %0d", $time,
               idx, want, got);
    end
  endtask

  task automatic set_thresholds(input int lo, input int hi, input int spread,
                                input int ratio, input int permille);
    write_threshold(lrsf_pkg::REG_MIN_RANGE, lo);
    write_threshold(lrsf_pkg::REG_MAX_RANGE, hi);
    write_threshold(lrsf_pkg::REG_MIN_SPREAD, spread);
    write_threshold(lrsf_pkg::REG_SPIKE_RAT, ratio);
    write_threshold(lrsf_pkg::REG_REL_JUMP, permille);
  endtask

  function automatic logic [RB-1:0] clamp_mm(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return RB'(v);
  endfunction

  task automatic queue_scan(input int vals[$]);
    foreach (vals[i])
      scan_samples_q.push_back('{range_mm: clamp_mm(vals[i]),
                                 last: (i == vals.size() - 1)});
    scans_queued++;
  endtask

  // Random scans. Most are a smooth surface with jitter and the odd spike
  // or dropout, so interior samples really exercise both tests; the rest are
  // pure noise over the whole 16-bit range.
  task automatic queue_random_scans(input int n_samples);
    int vals[$];
    int count, len, base, kind;
    count = 0;
    while (count < n_samples) begin
      vals.delete();
      len  = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      kind = $urandom_range(9, 0);
      base = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(1500, 20);
      for (int i = 0; i < len; i++) begin
        if (kind == 0)
          vals.push_back($urandom_range(65535, 0));
        else if ($urandom_range(19, 0) == 0)
          vals.push_back($urandom_range(1, 0) ? 65535 : 0);
        else if ($urandom_range(3, 0) == 0)
          vals.push_back($urandom_range(1, 0) ? base + $urandom_range(800, 50)
                                              : base - $urandom_range(800, 50));
        else
          vals.push_back(base + $urandom_range(20, 0) - 10);
      end
      queue_scan(vals);
      count += len;
    end
  endtask

  // Wait until everything queued has gone in and every result has come out,
  // then let the block settle before touching registers.
  task automatic drain;
    while (scan_samples_q.size() != 0 || in_valid || filtered_due_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Receiver-heavy idling first, then sender-heavy, then none at all.
      if (ph < 2) begin
        send_idle_pct = 36;
        recv_idle_pct = 62;
      end else if (ph < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (ph)
        0: begin
          // Reset thresholds: directed scans first. One-sample scans at both
          // extremes, a clear spike, samples at and just inside both range
          // bounds, a two-sample scan and a scan with no-return samples.
          queue_scan('{65535});
          queue_scan('{0});
          queue_scan('{100, 500, 100, 100});
          queue_scan('{500, 10, 500, 1000, 500, 999, 500, 11, 500});
          queue_scan('{200, 300});
          queue_scan('{0, 65535, 65535});
        end
        // Widest window with zero ratio and zero jump: almost any bump goes.
        1: set_thresholds(0, 65535, 1, 0, 0);
        // Empty window and the strictest tests: nothing may be replaced.
        2: set_thresholds(65535, 0, 65535, 15, 4095);
        // No floor on the spread.
        3: set_thresholds($urandom_range(50, 0), $urandom_range(65535, 1000), 0,
                          $urandom_range(3, 0), $urandom_range(800, 0));
        default: set_thresholds($urandom_range(200, 0), $urandom_range(65535, 500),
                                $urandom_range(50, 1), $urandom_range(15, 0),
                                $urandom_range(4095, 0));
      endcase

      queue_random_scans(RAND_ITEMS);
      drain();
    end

    repeat (20) @(posedge clk);
    if (filtered_due_q.size() != 0) begin
      errors++;
      $display("%0t: %0d filtered samples never came out", $time, filtered_due_q.size());
    end

    $display("Covered %0d scans, %0d samples in and %0d samples out over %0d threshold sets,",
             scans_queued, samples_sent, results_seen, NUM_PHASES);
    $display("with %0d spikes replaced and %0d errors.", spikes_fixed, errors);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- laser_range_spike_filter.f -----
hw/rtl/lrsf_pkg.sv
hw/rtl/lrsf_cfg_regs.sv
hw/rtl/lrsf_core.sv
hw/rtl/lrsf_out_fifo.sv
hw/rtl/laser_range_spike_filter.sv
hw/rtl/lrsf_checker.sv
tb/sv/laser_range_spike_filter_tb.sv
